[src/efp_pkg.sv]
// Shared types, constants and color tables for the escape-time fractal pixel.
// Depends on nothing; every other file refers to it by scoped names.
package efp_pkg;

    localparam int COORD_W    = 15;
    localparam int COMP_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W     = 31;
    localparam int ITER_W     = 16;
    localparam int COLOR_W    = 8;
    localparam int WIDE_W     = 66;

    localparam int BRIGHT_DIV   = 200;
    localparam int BRIGHT_MAX   = 255;
    localparam int BRIGHT_FLOOR = 20;

    localparam logic signed [31:0] RST_X_ORIGIN = -32'sd603979776;
    localparam logic [30:0]        RST_X_STEP   = 31'd33554;
    localparam logic signed [31:0] RST_Y_ORIGIN = -32'sd301989888;
    localparam logic [30:0]        RST_Y_STEP   = 31'd33554;
    localparam logic [15:0]        RST_MAX_ITER = 16'd5000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_ORIGIN   = 3'd0,
        REG_X_STEP     = 3'd1,
        REG_Y_ORIGIN   = 3'd2,
        REG_Y_STEP     = 3'd3,
        REG_MAX_ITER   = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_UPD,
        BK_BRIGHT,
        BK_OUT
    } t_bk_state;

    typedef struct packed {
        logic signed [COMP_W-1:0] x_origin;
        logic [STEP_W-1:0]        x_step;
        logic signed [COMP_W-1:0] y_origin;
        logic [STEP_W-1:0]        y_step;
    } t_win;

    typedef struct packed {
        logic signed [COMP_W-1:0] cr;
        logic signed [COMP_W-1:0] ci;
    } t_point;

    typedef logic [COLOR_W-1:0] t_lut8 [256];

    function automatic logic signed [COMP_W-1:0] f_sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = (WIDE_W'(1) <<< (COMP_W - 1)) - WIDE_W'(1);
        lo = -(WIDE_W'(1) <<< (COMP_W - 1));
        if (v > hi) begin
            return {1'b0, {(COMP_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(COMP_W-1){1'b0}}};
        end
        return v[COMP_W-1:0];
    endfunction

    function automatic t_lut8 f_bright_lut();
        t_lut8 t;
        int    v;
        for (int i = 0; i < 256; i++) begin
            v = (i * BRIGHT_MAX) / BRIGHT_DIV;
            if (v > BRIGHT_MAX) v = BRIGHT_MAX;
            if (v < BRIGHT_FLOOR) v = 0;
            t[i] = COLOR_W'(v);
        end
        return t;
    endfunction

    function automatic t_lut8 f_red_lut();
        t_lut8 t;
        for (int i = 0; i < 256; i++) begin
            t[i] = COLOR_W'((i * i) / BRIGHT_MAX);
        end
        return t;
    endfunction

    function automatic t_lut8 f_blue_lut();
        t_lut8 t;
        int    n;
        int    r;
        for (int i = 0; i < 256; i++) begin
            n = BRIGHT_MAX * i;
            r = 0;
            for (int k = 7; k >= 0; k--) begin
                if ((r + (1 << k)) * (r + (1 << k)) <= n) r = r + (1 << k);
            end
            t[i] = COLOR_W'(r);
        end
        return t;
    endfunction

    localparam t_lut8 BRIGHT_LUT = f_bright_lut();
    localparam t_lut8 RED_LUT    = f_red_lut();
    localparam t_lut8 BLUE_LUT   = f_blue_lut();

endpackage

[src/efp_if.sv]
// Handshake channels of the fractal pixel block: pixel requests, colors, register writes.
// Depends on efp_pkg for field widths.
interface efp_pix_if;
    logic                          valid;
    logic                          ready;
    logic [efp_pkg::COORD_W-1:0]   column;
    logic [efp_pkg::COORD_W-1:0]   row;
    modport source (output valid, output column, output row, input ready);
    modport sink   (input valid, input column, input row, output ready);
endinterface

interface efp_rgb_if;
    logic                          valid;
    logic                          ready;
    logic [efp_pkg::COLOR_W-1:0]   red;
    logic [efp_pkg::COLOR_W-1:0]   green;
    logic [efp_pkg::COLOR_W-1:0]   blue;
    logic [efp_pkg::ITER_W-1:0]    iteration_count;
    modport source (output valid, output red, output green, output blue,
                    output iteration_count, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input iteration_count, output ready);
endinterface

interface efp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [efp_pkg::CFG_IDX_W-1:0]   index;
    logic [efp_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/efp_front.sv]
// Front end: accepts pixel requests and maps column and row to the point c.
// Depends on efp_pkg and efp_pix_if.
module efp_front #(
    parameter int COORD_BITS = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    efp_pix_if.sink              i_pix,
    input  efp_pkg::t_win        i_win,
    output logic                 o_push_valid,
    input  logic                 i_push_ready,
    output efp_pkg::t_point      o_push_data
);
    localparam int CB = (COORD_BITS < efp_pkg::COORD_W) ? COORD_BITS : efp_pkg::COORD_W;
    localparam logic [efp_pkg::COORD_W-1:0] CMASK =
        efp_pkg::COORD_W'((17'd1 << CB) - 17'd1);
    localparam int PROD_W = efp_pkg::COORD_W + efp_pkg::STEP_W;
    localparam int SUM_W  = PROD_W + 2;

    logic              r_v1;
    logic [PROD_W-1:0] r_pr;
    logic [PROD_W-1:0] r_pi;
    logic              r_v2;
    efp_pkg::t_point   r_pt;

    logic                     w_adv1;
    logic                     w_adv2;
    logic                     w_load2;
    logic signed [SUM_W-1:0]  w_sr;
    logic signed [SUM_W-1:0]  w_si;

    assign w_adv2  = !r_v2 || i_push_ready;
    assign w_load2 = r_v1 && w_adv2;
    assign w_adv1  = !r_v1 || w_load2;
    assign i_pix.ready = w_adv1;

    assign w_sr = $signed({{(SUM_W-efp_pkg::COMP_W){i_win.x_origin[efp_pkg::COMP_W-1]}},
                           i_win.x_origin}) + $signed({2'b00, r_pr});
    assign w_si = $signed({{(SUM_W-efp_pkg::COMP_W){i_win.y_origin[efp_pkg::COMP_W-1]}},
                           i_win.y_origin}) + $signed({2'b00, r_pi});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_pix.valid;
            if (w_adv2) r_v2 <= r_v1;
        end
        if (w_adv1 && i_pix.valid) begin
            r_pr <= PROD_W'(i_pix.column & CMASK) * PROD_W'(i_win.x_step);
            r_pi <= PROD_W'(i_pix.row & CMASK) * PROD_W'(i_win.y_step);
        end
        if (w_load2) begin
            r_pt.cr <= efp_pkg::f_sat32($signed({{(efp_pkg::WIDE_W-SUM_W){w_sr[SUM_W-1]}}, w_sr}));
            r_pt.ci <= efp_pkg::f_sat32($signed({{(efp_pkg::WIDE_W-SUM_W){w_si[SUM_W-1]}}, w_si}));
        end
    end

    assign o_push_valid = r_v2;
    assign o_push_data  = r_pt;

endmodule

[src/efp_queue.sv]
// Two-entry queue of points between the front end and the iteration engine.
// Depends on efp_pkg.
module efp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  efp_pkg::t_point   i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output efp_pkg::t_point   o_pop_data
);
    efp_pkg::t_point r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign w_push = i_push_valid && o_push_ready;
    assign w_pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wp] <= i_push_data;
    end

endmodule

[src/efp_back.sv]
// Iteration engine: runs z = z*z + c on a shared multiplier set, then colors the count.
// Depends on efp_pkg and efp_rgb_if.
module efp_back #(
    parameter int FRACTION_BITS = 28
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_pop_valid,
    output logic                          o_pop_ready,
    input  efp_pkg::t_point               i_pop_data,
    input  logic [efp_pkg::ITER_W-1:0]    i_max_iter,
    efp_rgb_if.source                     o_rgb
);
    localparam int  W       = efp_pkg::WIDE_W;
    localparam int  CW      = efp_pkg::COMP_W;
    localparam bit  CAN_ESC = (2 * FRACTION_BITS + 2) < 64;
    localparam logic [63:0] BOUND = CAN_ESC ? (64'd1 << (2 * FRACTION_BITS + 2)) : 64'd0;

    efp_pkg::t_bk_state r_state;
    efp_pkg::t_bk_state n_state;

    logic signed [CW-1:0]   r_x;
    logic signed [CW-1:0]   r_y;
    logic signed [CW-1:0]   r_cr;
    logic signed [CW-1:0]   r_ci;
    logic signed [63:0]     r_xx;
    logic signed [63:0]     r_yy;
    logic signed [63:0]     r_xy;
    logic                   r_chk;
    logic [efp_pkg::ITER_W-1:0]  r_count;
    logic [efp_pkg::COLOR_W-1:0] r_bright;
    logic                        r_ov;
    logic [efp_pkg::COLOR_W-1:0] r_red;
    logic [efp_pkg::COLOR_W-1:0] r_green;
    logic [efp_pkg::COLOR_W-1:0] r_blue;
    logic [efp_pkg::ITER_W-1:0]  r_cnt_out;

    logic                   w_pop;
    logic                   w_load_out;
    logic signed [W-1:0]    w_cr_e;
    logic signed [W-1:0]    w_ci_e;
    logic signed [W-1:0]    w_dx;
    logic signed [W-1:0]    w_nx;
    logic signed [W-1:0]    w_ny;
    logic [63:0]            w_mag;
    logic                   w_esc;
    logic [efp_pkg::ITER_W-1:0]  w_cnt_inc;
    logic                        w_at_max;
    logic [efp_pkg::COLOR_W-1:0] w_bright;

    assign w_cr_e = $signed({{(W-CW){r_cr[CW-1]}}, r_cr});
    assign w_ci_e = $signed({{(W-CW){r_ci[CW-1]}}, r_ci});
    assign w_dx   = $signed({{(W-64){r_xx[63]}}, r_xx}) - $signed({{(W-64){r_yy[63]}}, r_yy});
    assign w_nx   = (w_dx >>> FRACTION_BITS) + w_cr_e;
    assign w_ny   = ($signed({{(W-64){r_xy[63]}}, r_xy}) >>> (FRACTION_BITS - 1)) + w_ci_e;
    assign w_mag  = $unsigned(r_xx) + $unsigned(r_yy);
    assign w_esc  = CAN_ESC && (w_mag > BOUND);
    assign w_cnt_inc = r_count + efp_pkg::ITER_W'(1);
    assign w_at_max  = (w_cnt_inc == i_max_iter);

    always_comb begin
        if (r_count == i_max_iter) begin
            w_bright = '0;
        end else if (r_count > efp_pkg::ITER_W'(255)) begin
            w_bright = efp_pkg::COLOR_W'(efp_pkg::BRIGHT_MAX);
        end else begin
            w_bright = efp_pkg::BRIGHT_LUT[r_count[7:0]];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            efp_pkg::BK_IDLE: begin
                if (i_pop_valid) begin
                    n_state = (i_max_iter == '0) ? efp_pkg::BK_BRIGHT : efp_pkg::BK_MUL;
                end
            end
            efp_pkg::BK_MUL: n_state = efp_pkg::BK_UPD;
            efp_pkg::BK_UPD: begin
                if (r_chk && (w_esc || w_at_max)) begin
                    n_state = efp_pkg::BK_BRIGHT;
                end else begin
                    n_state = efp_pkg::BK_MUL;
                end
            end
            efp_pkg::BK_BRIGHT: n_state = efp_pkg::BK_OUT;
            efp_pkg::BK_OUT: begin
                if (!r_ov || o_rgb.ready) n_state = efp_pkg::BK_IDLE;
            end
            default: n_state = efp_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        w_pop      = (r_state == efp_pkg::BK_IDLE) && i_pop_valid;
        w_load_out = (r_state == efp_pkg::BK_OUT) && (!r_ov || o_rgb.ready);
    end

    assign o_pop_ready = (r_state == efp_pkg::BK_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= efp_pkg::BK_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (o_rgb.ready) begin
                r_ov <= 1'b0;
            end
        end
        if (w_pop) begin
            r_x     <= i_pop_data.cr;
            r_y     <= i_pop_data.ci;
            r_cr    <= i_pop_data.cr;
            r_ci    <= i_pop_data.ci;
            r_count <= '0;
            r_chk   <= 1'b0;
        end
        if (r_state == efp_pkg::BK_MUL) begin
            r_xx <= 64'(r_x) * 64'(r_x);
            r_yy <= 64'(r_y) * 64'(r_y);
            r_xy <= 64'(r_x) * 64'(r_y);
        end
        if (r_state == efp_pkg::BK_UPD) begin
            if (r_chk && !w_esc) r_count <= w_cnt_inc;
            r_x   <= efp_pkg::f_sat32(w_nx);
            r_y   <= efp_pkg::f_sat32(w_ny);
            r_chk <= 1'b1;
        end
        if (r_state == efp_pkg::BK_BRIGHT) begin
            r_bright <= w_bright;
        end
        if (w_load_out) begin
            r_red     <= efp_pkg::RED_LUT[r_bright];
            r_green   <= r_bright;
            r_blue    <= efp_pkg::BLUE_LUT[r_bright];
            r_cnt_out <= r_count;
        end
    end

    assign o_rgb.valid           = r_ov;
    assign o_rgb.red             = r_red;
    assign o_rgb.green           = r_green;
    assign o_rgb.blue            = r_blue;
    assign o_rgb.iteration_count = r_cnt_out;

endmodule

[src/escape_time_fractal_pixel.sv]
// Escape-time fractal pixel: each request (column, row) returns one color and the
// iteration count. The front end maps the pixel to c via a product and a sum register
// and parks it in a two-entry queue, so it keeps taking requests while the engine works,
// until the queue fills. The engine alternates a multiply and an update state per
// iteration on one set of three 32x32 multipliers and takes a new point only when idle,
// once the last color is loaded for output; that loop sets the throughput. A stalled
// color output holds the engine until it drains. Registers are to be written through the
// configuration channel only while no pixel is in flight; the block does not enforce it.
// Depends on efp_pkg, efp_if, efp_front, efp_queue and efp_back.
module escape_time_fractal_pixel #(
    parameter int FRACTION_BITS = 28,
    parameter int COORD_BITS    = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    efp_pix_if.sink     i_pix,
    efp_cfg_if.sink     i_cfg,
    efp_rgb_if.source   o_rgb
);
    efp_pkg::t_win                 r_win;
    logic [efp_pkg::ITER_W-1:0]    r_max_iter;

    logic              w_push_valid;
    logic              w_push_ready;
    efp_pkg::t_point   w_push_data;
    logic              w_pop_valid;
    logic              w_pop_ready;
    efp_pkg::t_point   w_pop_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.x_origin <= efp_pkg::RST_X_ORIGIN;
            r_win.x_step   <= efp_pkg::RST_X_STEP;
            r_win.y_origin <= efp_pkg::RST_Y_ORIGIN;
            r_win.y_step   <= efp_pkg::RST_Y_STEP;
            r_max_iter     <= efp_pkg::RST_MAX_ITER;
        end else if (i_cfg.valid) begin
            case (efp_pkg::t_reg_idx'(i_cfg.index))
                efp_pkg::REG_X_ORIGIN: r_win.x_origin <= i_cfg.data;
                efp_pkg::REG_X_STEP:   r_win.x_step   <= i_cfg.data[efp_pkg::STEP_W-1:0];
                efp_pkg::REG_Y_ORIGIN: r_win.y_origin <= i_cfg.data;
                efp_pkg::REG_Y_STEP:   r_win.y_step   <= i_cfg.data[efp_pkg::STEP_W-1:0];
                efp_pkg::REG_MAX_ITER: r_max_iter     <= i_cfg.data[efp_pkg::ITER_W-1:0];
                default: ;
            endcase
        end
    end

    efp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (i_pix),
        .i_win        (r_win),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    efp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    efp_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .i_max_iter  (r_max_iter),
        .o_rgb       (o_rgb)
    );

endmodule
